FILE: rtl/core/ipsmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipsmt_pkg;

  localparam int ADD_W = 36;

  typedef struct packed {
    logic        first_in_sequence;
    logic        is_maintenance;
    logic [30:0] start_time;
    logic [3:0]  size_class;
    logic [15:0] duration;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] idle_time;
    logic [30:0]        max_idle;
    logic               trigger;
    logic               action_type;
  } out_beat_t;

  typedef enum logic [2:0] {
    REG_MODE_STRICT  = 3'd0,
    REG_SIZES_IN_USE = 3'd1,
    REG_TYPE_COUNT   = 3'd2,
    REG_LOW_LIMIT_A  = 3'd3,
    REG_HIGH_LIMIT_A = 3'd4,
    REG_LOW_LIMIT_B  = 3'd5,
    REG_HIGH_LIMIT_B = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_VAL,
    ST_SWEEP,
    ST_MUL,
    ST_CHK,
    ST_DONE
  } state_t;

  // saturate a wide signed sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [ADD_W-1:0] v);
    logic signed [ADD_W-1:0] hi_lim;
    logic signed [ADD_W-1:0] lo_lim;
    hi_lim = ADD_W'(64'sh0000_0000_7FFF_FFFF);
    lo_lim = -hi_lim - ADD_W'(1);
    if (v > hi_lim) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo_lim) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/idle_per_size_maintenance_trigger.sv
// Latency from input beat to result beat grows with SIZE_CLASSES and is set by the number
// of threshold types checked, plus any wait on a held result beat.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// The item time is set by the sweep of one shared adder over the idle table RAM.
// Reset (rst_n low, synchronous) clears control, config and history; the idle table
// reads as zero until the first sweep has rewritten every entry.
`timescale 1ns / 1ps
`default_nettype none

module idle_per_size_maintenance_trigger #(
  parameter int SIZE_CLASSES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ipsmt_pkg::in_beat_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ipsmt_pkg::out_beat_t      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_addr,
  input  wire logic [30:0]          cfg_data
);

  localparam int IW = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int AW = ipsmt_pkg::ADD_W;

  ipsmt_pkg::state_t state_r, state_nxt;

  logic        mode_strict_r;
  logic [15:0] sizes_in_use_r;
  logic [1:0]  type_count_r;
  logic [30:0] low_a_r, high_a_r, low_b_r, high_b_r;

  ipsmt_pkg::in_beat_t cur_r;
  logic [IW-1:0]       cur_size_r;
  logic [30:0]         last_start_r;
  logic [IW-1:0]       last_size_r;
  logic                last_maint_r;
  logic [15:0]         last_dur_r;

  logic signed [31:0] gap_r, val_r, idle_r;
  logic [30:0]        max_r;
  logic [AW-1:0]      max10_r;
  logic [IW:0]        cnt_r;
  logic               zero_r;
  logic               t_r, trig_r, act_r;
  logic               out_valid_r;
  ipsmt_pkg::out_beat_t out_data_r;

  logic signed [AW-1:0] add_a, add_b, add_sum;
  logic                 add_sub;
  logic [IW-1:0]        idx;
  logic signed [31:0]   old_val, new_val;
  logic                 ram_we;
  logic [31:0]          ram_rdata;
  logic [30:0]          lo_sel, hi_sel;
  logic [1:0]           ntypes;
  logic                 match;
  logic                 in_mask;
  logic                 in_take;
  logic                 out_free;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign idx      = IW'(cnt_r - (IW + 1)'(1));
  assign old_val  = zero_r ? 32'sd0 : $signed(ram_rdata);
  assign add_sum  = add_sub ? (add_a - add_b) : (add_a + add_b);
  assign ntypes   = (type_count_r == 2'd3) ? 2'd2 : type_count_r;
  assign lo_sel   = t_r ? low_b_r : low_a_r;
  assign hi_sel   = t_r ? high_b_r : high_a_r;
  assign in_mask  = (32'(idx) < 16) && sizes_in_use_r[4'(idx)];

  always_comb begin
    match = (idle_r >= $signed({1'b0, lo_sel})) && (idle_r < $signed({1'b0, hi_sel}));
    if (!mode_strict_r && (max10_r >= add_sum) && (max_r < hi_sel)) begin
      match = 1'b1;
    end
  end

  always_comb begin
    if (cur_r.first_in_sequence || cur_r.is_maintenance) begin
      new_val = 32'sd0;
    end else if (last_maint_r || (idx <= last_size_r)) begin
      new_val = val_r;
    end else begin
      new_val = ipsmt_pkg::sat32(add_sum);
    end
  end

  ipsmt_ram #(
    .WIDTH(32),
    .DEPTH(SIZE_CLASSES)
  ) u_idle_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(new_val),
    .raddr(cnt_r[IW-1:0]),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ipsmt_pkg::ST_IDLE: begin
        if (in_take) state_nxt = ipsmt_pkg::ST_GAP;
      end
      ipsmt_pkg::ST_GAP:   state_nxt = ipsmt_pkg::ST_VAL;
      ipsmt_pkg::ST_VAL:   state_nxt = ipsmt_pkg::ST_SWEEP;
      ipsmt_pkg::ST_SWEEP: begin
        if (cnt_r == (IW + 1)'(SIZE_CLASSES)) state_nxt = ipsmt_pkg::ST_MUL;
      end
      ipsmt_pkg::ST_MUL: begin
        state_nxt = (ntypes == 2'd0) ? ipsmt_pkg::ST_DONE : ipsmt_pkg::ST_CHK;
      end
      ipsmt_pkg::ST_CHK: begin
        if (match || t_r || (ntypes == 2'd1)) state_nxt = ipsmt_pkg::ST_DONE;
      end
      ipsmt_pkg::ST_DONE: begin
        if (out_free) state_nxt = ipsmt_pkg::ST_IDLE;
      end
      default: state_nxt = ipsmt_pkg::ST_IDLE;
    endcase
  end

  // shared adder operands and control outputs
  always_comb begin
    add_a    = '0;
    add_b    = '0;
    add_sub  = 1'b0;
    ram_we   = 1'b0;
    in_stall = 1'b1;
    unique case (state_r)
      ipsmt_pkg::ST_IDLE: in_stall = 1'b0;
      ipsmt_pkg::ST_GAP: begin
        add_a   = AW'(cur_r.start_time);
        add_b   = AW'(last_start_r);
        add_sub = 1'b1;
      end
      ipsmt_pkg::ST_VAL: begin
        add_a   = AW'(gap_r);
        add_b   = AW'(last_dur_r);
        add_sub = 1'b1;
      end
      ipsmt_pkg::ST_SWEEP: begin
        add_a  = AW'(old_val);
        add_b  = AW'(gap_r);
        ram_we = (cnt_r != '0);
      end
      ipsmt_pkg::ST_MUL: begin
        add_a = AW'({max_r, 3'b000});
        add_b = AW'({max_r, 1'b0});
      end
      ipsmt_pkg::ST_CHK: begin
        add_a = AW'({hi_sel, 3'b000});
        add_b = AW'(hi_sel);
      end
      ipsmt_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ipsmt_pkg::ST_IDLE;
      mode_strict_r  <= 1'b0;
      sizes_in_use_r <= 16'hFFFF;
      type_count_r   <= 2'd1;
      low_a_r        <= '0;
      high_a_r       <= '0;
      low_b_r        <= '0;
      high_b_r       <= '0;
      last_start_r   <= '0;
      last_size_r    <= '0;
      last_maint_r   <= 1'b0;
      last_dur_r     <= '0;
      zero_r         <= 1'b1;
      out_valid_r    <= 1'b0;
      cnt_r          <= '0;
      t_r            <= 1'b0;
      trig_r         <= 1'b0;
      act_r          <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (ipsmt_pkg::reg_idx_t'(cfg_addr))
          ipsmt_pkg::REG_MODE_STRICT:  mode_strict_r  <= cfg_data[0];
          ipsmt_pkg::REG_SIZES_IN_USE: sizes_in_use_r <= cfg_data[15:0];
          ipsmt_pkg::REG_TYPE_COUNT:   type_count_r   <= cfg_data[1:0];
          ipsmt_pkg::REG_LOW_LIMIT_A:  low_a_r        <= cfg_data;
          ipsmt_pkg::REG_HIGH_LIMIT_A: high_a_r       <= cfg_data;
          ipsmt_pkg::REG_LOW_LIMIT_B:  low_b_r        <= cfg_data;
          ipsmt_pkg::REG_HIGH_LIMIT_B: high_b_r       <= cfg_data;
          ipsmt_pkg::REG_UNUSED:       ;
          default:                     ;
        endcase
      end

      if (out_valid_r && !out_stall && (state_r != ipsmt_pkg::ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ipsmt_pkg::ST_IDLE: begin
          if (in_take) begin
            cur_r      <= in_data;
            cur_size_r <= (32'(in_data.size_class) >= SIZE_CLASSES) ?
                          IW'(SIZE_CLASSES - 1) : IW'(in_data.size_class);
          end
        end
        ipsmt_pkg::ST_GAP: gap_r <= add_sum[31:0];
        ipsmt_pkg::ST_VAL: begin
          val_r  <= ipsmt_pkg::sat32(add_sum);
          max_r  <= '0;
          idle_r <= '0;
          cnt_r  <= '0;
        end
        ipsmt_pkg::ST_SWEEP: begin
          cnt_r <= cnt_r + (IW + 1)'(1);
          if (cnt_r != '0) begin
            if (idx == cur_size_r && !cur_r.is_maintenance) idle_r <= new_val;
            if (!cur_r.is_maintenance && in_mask && (new_val > $signed({1'b0, max_r}))) begin
              max_r <= new_val[30:0];
            end
          end
          if (cnt_r == (IW + 1)'(SIZE_CLASSES)) zero_r <= 1'b0;
        end
        ipsmt_pkg::ST_MUL: begin
          max10_r      <= add_sum;
          t_r          <= 1'b0;
          trig_r       <= 1'b0;
          act_r        <= 1'b0;
          last_start_r <= cur_r.start_time;
          last_size_r  <= cur_size_r;
          last_maint_r <= cur_r.is_maintenance;
          last_dur_r   <= cur_r.duration;
        end
        ipsmt_pkg::ST_CHK: begin
          if (match) begin
            trig_r <= 1'b1;
            act_r  <= t_r;
          end
          t_r <= 1'b1;
        end
        ipsmt_pkg::ST_DONE: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.idle_time   <= idle_r;
            out_data_r.max_idle    <= max_r;
            out_data_r.trigger     <= trig_r;
            out_data_r.action_type <= act_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/ipsmt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ipsmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
